>>> rtl/ctslm_pkg.sv
// ----------------------------------------------------------------------------
// ctslm_pkg
// Shared types, constants and the local-minimum update used by the scan
// stage and the wrap-around stages of the two-smallest-minima finder.
// ----------------------------------------------------------------------------
package ctslm_pkg;

  // Widths of the sample, label index, register and curvature fields
  localparam int SAMPLE_W = 32;
  localparam int LABEL_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int CURV_W   = 34;

  // Label count limits and register reset value
  localparam int                 MAX_LABELS_DEFAULT = 256;
  localparam int                 LABEL_CAP          = 256;
  localparam logic [COUNT_W-1:0] LABEL_MIN          = 9'd3;
  localparam logic [COUNT_W-1:0] NUM_LABELS_RESET   = 9'd100;

  // Minima count codes
  localparam logic [1:0] MINIMA_NONE = 2'd0;
  localparam logic [1:0] MINIMA_ONE  = 2'd1;
  localparam logic [1:0] MINIMA_SAT  = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [CURV_W-1:0]   curv_t;
  typedef logic        [LABEL_W-1:0]  label_t;

  // Two smallest minima seen so far in a voxel
  typedef struct packed {
    sample_t    best_value;
    label_t     best_index;
    curv_t      best_curvature;
    sample_t    runner_value;
    label_t     runner_index;
    logic [1:0] count;
  } track_t;

  // Hand-off from the scan stage on the last word of a voxel
  typedef struct packed {
    track_t  trk;
    sample_t prev;
    sample_t cur;
    sample_t first;
    sample_t second;
    label_t  pos;
  } snap_t;

  // Circular second difference lo + hi - 2*mid, exact in 34 bits
  function automatic curv_t second_diff(input sample_t lo, input sample_t mid,
                                        input sample_t hi);
    return curv_t'(lo) + curv_t'(hi) - (curv_t'(mid) <<< 1);
  endfunction

  // Order by value, then by lower index
  function automatic logic lex_less(input sample_t va, input label_t ia,
                                    input sample_t vb, input label_t ib);
    return (va < vb) || ((va == vb) && (ia < ib));
  endfunction

  // Test position idx and fold it into the running two smallest minima
  function automatic track_t consider(input track_t trk, input sample_t lo,
                                      input sample_t mid, input sample_t hi,
                                      input label_t idx);
    track_t n;
    n = trk;
    if ((mid < lo) && (hi >= mid)) begin
      if (trk.count == MINIMA_NONE) begin
        n.best_value     = mid;
        n.best_index     = idx;
        n.best_curvature = second_diff(lo, mid, hi);
      end else if (lex_less(mid, idx, trk.best_value, trk.best_index)) begin
        n.runner_value   = trk.best_value;
        n.runner_index   = trk.best_index;
        n.best_value     = mid;
        n.best_index     = idx;
        n.best_curvature = second_diff(lo, mid, hi);
      end else if ((trk.count == MINIMA_ONE) ||
                   lex_less(mid, idx, trk.runner_value, trk.runner_index)) begin
        n.runner_value = mid;
        n.runner_index = idx;
      end
      if (trk.count < MINIMA_SAT) begin
        n.count = trk.count + 2'd1;
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/ctslm_scan.sv
// ----------------------------------------------------------------------------
// ctslm_scan
// Per-voxel scan: keeps the last two samples and the first two of the voxel,
// tests the middle position of each window of three, and hands a snapshot
// to the wrap-around stages on the last word of the voxel.
// ----------------------------------------------------------------------------
module ctslm_scan #(
  parameter int MAX_LABELS = ctslm_pkg::MAX_LABELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ctslm_pkg::COUNT_W-1:0]       num_labels,
  input  logic                                take,
  input  ctslm_pkg::sample_t                  residual,
  output logic                                push,
  output ctslm_pkg::snap_t                    snap
);

  // Highest usable label count
  localparam logic [ctslm_pkg::COUNT_W-1:0] LABEL_HI =
    ctslm_pkg::COUNT_W'((MAX_LABELS < ctslm_pkg::LABEL_CAP) ?
                        MAX_LABELS : ctslm_pkg::LABEL_CAP);

  logic [ctslm_pkg::LABEL_W-1:0] position;
  ctslm_pkg::track_t             trk;
  ctslm_pkg::track_t             trk_next;
  ctslm_pkg::sample_t            first_sample;
  ctslm_pkg::sample_t            second_sample;
  ctslm_pkg::sample_t            older_sample;
  ctslm_pkg::sample_t            newer_sample;
  logic [ctslm_pkg::COUNT_W-1:0] labels;
  logic                          last;

  // Clamp the label count and detect the last word of the voxel
  always_comb begin
    if (num_labels > LABEL_HI) begin
      labels = LABEL_HI;
    end else if (num_labels < ctslm_pkg::LABEL_MIN) begin
      labels = ctslm_pkg::LABEL_MIN;
    end else begin
      labels = num_labels;
    end
    last = ({1'b0, position} + 9'd1) >= labels;
  end

  // Test the position before the current word
  always_comb begin
    if (position >= 8'd2) begin
      trk_next = ctslm_pkg::consider(trk, older_sample, newer_sample, residual,
                                     position - 8'd1);
    end else begin
      trk_next = trk;
    end
    push            = take && last;
    snap.trk        = trk_next;
    snap.prev       = newer_sample;
    snap.cur        = residual;
    snap.first      = first_sample;
    snap.second     = second_sample;
    snap.pos        = position;
  end

  // Advance position and minima, clear both at the end of a voxel
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      trk      <= '0;
    end else if (take) begin
      if (last) begin
        position <= '0;
        trk      <= '0;
      end else begin
        position <= position + 8'd1;
        trk      <= trk_next;
      end
    end
  end

  // Hold the sample window
  always_ff @(posedge clk) begin
    if (take) begin
      if (position == 8'd0) begin
        first_sample <= residual;
      end
      if (position == 8'd1) begin
        second_sample <= residual;
      end
      older_sample <= newer_sample;
      newer_sample <= residual;
    end
  end

  // Position stays inside the clamped period
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, position} < LABEL_HI)
    else $error("scan position beyond label range");

  // Minima count saturates at two
  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    trk.count != 2'd3)
    else $error("minima count past saturation");

endmodule

>>> rtl/ctslm_wrap.sv
// ----------------------------------------------------------------------------
// ctslm_wrap
// Closes the circle of a finished voxel: tests the last position, then
// position zero, and forms the result word in the output register.
// ----------------------------------------------------------------------------
module ctslm_wrap (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  ctslm_pkg::snap_t                snap,
  output logic                            room,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ctslm_pkg::label_t               first_minimum,
  output ctslm_pkg::label_t               second_minimum,
  output ctslm_pkg::curv_t                curvature,
  output logic [1:0]                      minima_found
);

  logic               a_valid;
  ctslm_pkg::snap_t   a_snap;
  logic               b_valid;
  ctslm_pkg::track_t  b_trk;
  ctslm_pkg::track_t  b_trk_next;
  ctslm_pkg::sample_t b_cur;
  ctslm_pkg::sample_t b_first;
  ctslm_pkg::sample_t b_second;
  ctslm_pkg::track_t  f_trk;
  logic               out_free;
  logic               b_free;

  // Each stage moves when the one after it has room
  always_comb begin
    out_free = !out_valid || !out_stall;
    b_free   = !b_valid || out_free;
    room     = !a_valid || b_free;
  end

  // Test the last position, then position zero
  always_comb begin
    b_trk_next = ctslm_pkg::consider(a_snap.trk, a_snap.prev, a_snap.cur,
                                     a_snap.first, a_snap.pos);
    f_trk      = ctslm_pkg::consider(b_trk, b_cur, b_first, b_second, '0);
  end

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (room) begin
        a_valid <= push;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (out_free) begin
        out_valid <= b_valid;
      end
    end
  end

  // Hold stage payloads and form the result word
  always_ff @(posedge clk) begin
    if (room) begin
      a_snap <= snap;
    end
    if (b_free) begin
      b_trk    <= b_trk_next;
      b_cur    <= a_snap.cur;
      b_first  <= a_snap.first;
      b_second <= a_snap.second;
    end
    if (out_free) begin
      minima_found <= f_trk.count;
      if (f_trk.count == ctslm_pkg::MINIMA_NONE) begin
        first_minimum  <= '0;
        second_minimum <= '0;
        curvature      <= ctslm_pkg::second_diff(b_cur, b_first, b_second);
      end else begin
        first_minimum  <= f_trk.best_index;
        second_minimum <= (f_trk.count == ctslm_pkg::MINIMA_SAT) ?
                          f_trk.runner_index : f_trk.best_index;
        curvature      <= f_trk.best_curvature;
      end
    end
  end

  // No minimum reports index zero twice
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (minima_found == ctslm_pkg::MINIMA_NONE) |->
      (first_minimum == '0) && (second_minimum == '0))
    else $error("empty result with nonzero index");

  // A single minimum is reported twice
  a_one_same: assert property (@(posedge clk) disable iff (rst)
    out_valid && (minima_found == ctslm_pkg::MINIMA_ONE) |->
      second_minimum == first_minimum)
    else $error("single minimum reported with two indexes");

  // Two minima sit at distinct positions
  a_two_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && (minima_found == ctslm_pkg::MINIMA_SAT) |->
      second_minimum != first_minimum)
    else $error("two minima at the same index");

endmodule

>>> rtl/circular_two_smallest_local_minima_core.sv
// ----------------------------------------------------------------------------
// circular_two_smallest_local_minima_core
// Finds the two smallest local minima of a periodic residual curve per voxel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / residual) takes one Q16.16 residual
//   word per cycle unless stalled, in label order; voxels follow with no gap.
//   After the last word of a voxel (num_labels words, clamped to 3..256) one
//   result word leaves on the output channel (out_valid / out_stall) with
//   first_minimum, second_minimum, curvature and minima_found.
//   Throughput: one residual word per cycle, sustained unless in_stall rises.
//   The snapshot taken with the last word of a voxel enters the first
//   wrap-around stage; the test of the last position loads the second stage,
//   and the test of position zero loads the output register, which raises
//   out_valid.
//   A stalled result is held; the block keeps taking words and raises
//   in_stall only when both wrap-around stages and the output register hold
//   results.
//   num_labels is written through cfg_write / cfg_data while idle; the user
//   keeps to this, the block does not enforce it. Reset (rst, synchronous)
//   restores num_labels to 100, empties the pipeline and starts a fresh voxel.
// ----------------------------------------------------------------------------
module circular_two_smallest_local_minima_core #(
  parameter int MAX_LABELS = ctslm_pkg::MAX_LABELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ctslm_pkg::COUNT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ctslm_pkg::sample_t            residual,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ctslm_pkg::label_t             first_minimum,
  output ctslm_pkg::label_t             second_minimum,
  output ctslm_pkg::curv_t              curvature,
  output logic [1:0]                    minima_found
);

  logic [ctslm_pkg::COUNT_W-1:0] num_labels;
  logic                          take;
  logic                          push;
  logic                          room;
  ctslm_pkg::snap_t              snap;

  // Hold the label count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels <= ctslm_pkg::NUM_LABELS_RESET;
    end else if (cfg_write) begin
      num_labels <= cfg_data;
    end
  end

  // Input handshake
  assign in_stall = !room;
  assign take     = in_valid && room;

  ctslm_scan #(
    .MAX_LABELS (MAX_LABELS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .num_labels (num_labels),
    .take       (take),
    .residual   (residual),
    .push       (push),
    .snap       (snap)
  );

  ctslm_wrap u_wrap (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .snap           (snap),
    .room           (room),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .first_minimum  (first_minimum),
    .second_minimum (second_minimum),
    .curvature      (curvature),
    .minima_found   (minima_found)
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular two-smallest-minima core. A short
// table of hand-built voxels, some with hand-computed results, is followed by
// random voxels at many label counts, including the clamped extremes. Other
// result words are compared with a software scan of the same residual stream.
// Both channels idle and stall at random, and the output is once held off
// long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT        = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 60;
  localparam int LABEL_HI     =
    (ctslm_pkg::MAX_LABELS_DEFAULT < ctslm_pkg::LABEL_CAP) ?
    ctslm_pkg::MAX_LABELS_DEFAULT : ctslm_pkg::LABEL_CAP;
  localparam ctslm_pkg::sample_t S_MAX = 32'sh7FFFFFFF;
  localparam ctslm_pkg::sample_t S_MIN = 32'sh80000000;

  typedef enum int {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_t;
  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_FLAT, SHAPE_EDGES} shape_t;

  typedef struct packed {
    ctslm_pkg::label_t first;
    ctslm_pkg::label_t second;
    ctslm_pkg::curv_t  curv;
    logic [1:0]        found;
  } minima_res_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [8:0]         cfg;
    ctslm_pkg::sample_t word;
    bit                 typed;
    minima_res_t        want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [ctslm_pkg::COUNT_W-1:0] cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  ctslm_pkg::sample_t            residual = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ctslm_pkg::label_t             first_minimum;
  ctslm_pkg::label_t             second_minimum;
  ctslm_pkg::curv_t              curvature;
  logic [1:0]                    minima_found;

  circular_two_smallest_local_minima_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .residual       (residual),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .first_minimum  (first_minimum),
    .second_minimum (second_minimum),
    .curvature      (curvature),
    .minima_found   (minima_found)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scan state of the software copy
  logic [8:0]         labels_reg = ctslm_pkg::NUM_LABELS_RESET;
  logic [7:0]         scan_pos = '0;
  ctslm_pkg::sample_t head0 = '0, head1 = '0, prev2 = '0, prev1 = '0;
  ctslm_pkg::sample_t best_v = '0, run_v = '0;
  ctslm_pkg::label_t  best_i = '0, run_i = '0;
  ctslm_pkg::curv_t   best_c = '0;
  logic [1:0]         cnt = ctslm_pkg::MINIMA_NONE;

  minima_res_t        pending_q[$];
  dir_row_t           dir_tab[$];
  pace_t              pace = PACE_SLOW_RX;
  shape_t             voxel_shape = SHAPE_WIDE;
  ctslm_pkg::sample_t voxel_level = '0;
  bit                 hold_req = 1'b0;
  bit                 hold_started = 1'b0;
  int                 hold_left = 0;
  int                 cycles = 0;
  int                 errors = 0;

  // Append one expected result word
  function automatic void queue_result(input minima_res_t r);
    pending_q = {pending_q, r};
  endfunction

  // Append one row of the directed table
  function automatic void add_row(input dir_row_t d);
    dir_tab = {dir_tab, d};
  endfunction

  function automatic bit ranks_below(input longint va, input ctslm_pkg::label_t ia,
                                     input longint vb, input ctslm_pkg::label_t ib);
    return (va < vb) || ((va == vb) && (ia < ib));
  endfunction

  // Test one position and fold it into the two smallest minima
  function automatic void fold_minimum(input longint lo, input longint mid,
                                       input longint hi, input ctslm_pkg::label_t idx);
    ctslm_pkg::curv_t c;
    if (!((mid < lo) && (hi >= mid))) return;
    c = ctslm_pkg::curv_t'(lo + hi - 2 * mid);
    if (cnt == ctslm_pkg::MINIMA_NONE) begin
      best_v = ctslm_pkg::sample_t'(mid); best_i = idx; best_c = c;
    end else if (ranks_below(mid, idx, best_v, best_i)) begin
      run_v = best_v; run_i = best_i;
      best_v = ctslm_pkg::sample_t'(mid); best_i = idx; best_c = c;
    end else if (cnt == ctslm_pkg::MINIMA_ONE || ranks_below(mid, idx, run_v, run_i)) begin
      run_v = ctslm_pkg::sample_t'(mid); run_i = idx;
    end
    if (cnt < ctslm_pkg::MINIMA_SAT) cnt = cnt + 2'd1;
  endfunction

  function automatic void clear_scan();
    head0 = '0; head1 = '0; prev2 = '0; prev1 = '0;
    scan_pos = '0;
    best_v = '0; best_i = '0; best_c = '0;
    run_v = '0; run_i = '0;
    cnt = ctslm_pkg::MINIMA_NONE;
  endfunction

  // Advance the scan by one residual word; return 1 when a voxel closes
  function automatic bit advance_scan(input ctslm_pkg::sample_t w, output minima_res_t r);
    int unsigned t;
    int unsigned p;
    longint cur;
    t = labels_reg;
    if (t > LABEL_HI) t = LABEL_HI;
    if (t < ctslm_pkg::LABEL_MIN) t = ctslm_pkg::LABEL_MIN;
    p = scan_pos;
    cur = w;
    r = '0;
    if (p == 0) head0 = w;
    if (p == 1) head1 = w;
    if (p >= 2) fold_minimum(prev2, prev1, cur, ctslm_pkg::label_t'(p - 1));
    if (p + 1 < t) begin
      prev2 = prev1;
      prev1 = w;
      scan_pos = 8'(p + 1);
      return 1'b0;
    end
    // close the wrap-around at the last position and at position zero
    fold_minimum(prev1, cur, head0, ctslm_pkg::label_t'(p));
    fold_minimum(cur, head0, head1, ctslm_pkg::label_t'(0));
    if (cnt == ctslm_pkg::MINIMA_NONE) begin
      r.curv = ctslm_pkg::curv_t'(cur + longint'(head1) - 2 * longint'(head0));
    end else begin
      r.first  = best_i;
      r.second = (cnt >= ctslm_pkg::MINIMA_SAT) ? run_i : best_i;
      r.curv   = best_c;
    end
    r.found = cnt;
    clear_scan();
    return 1'b1;
  endfunction

  function automatic int send_idle_pct();
    case (pace)
      PACE_SLOW_RX: return 18;
      PACE_SLOW_TX: return 72;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (pace)
      PACE_SLOW_RX: return 72;
      PACE_SLOW_TX: return 18;
      default:      return 0;
    endcase
  endfunction

  // Draw the next residual word in the style of the current voxel
  function automatic ctslm_pkg::sample_t pick_residual();
    int v;
    case (voxel_shape)
      SHAPE_NARROW: begin
        v = $urandom_range(6);
        return ctslm_pkg::sample_t'(v - 3);
      end
      SHAPE_FLAT: return voxel_level;
      SHAPE_EDGES: begin
        case ($urandom_range(6))
          0:       return S_MIN;
          1:       return S_MIN + 1;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          5:       return S_MAX - 1;
          default: return S_MAX;
        endcase
      end
      default: return ctslm_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic dir_row_t mk_cfg(input logic [8:0] v);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.cfg = v;
    return d;
  endfunction

  function automatic dir_row_t mk_word(input ctslm_pkg::sample_t v);
    dir_row_t d;
    d = '0;
    d.word = v;
    return d;
  endfunction

  function automatic dir_row_t mk_last(input ctslm_pkg::sample_t v,
                                       input ctslm_pkg::label_t f,
                                       input ctslm_pkg::label_t s,
                                       input ctslm_pkg::curv_t c,
                                       input logic [1:0] n);
    dir_row_t d;
    d = mk_word(v);
    d.typed = 1'b1;
    d.want = '{first: f, second: s, curv: c, found: n};
    return d;
  endfunction

  // Drop valid and hold until every expected result has left the block
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_labels(input logic [8:0] v);
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    labels_reg = v;
  endtask

  // Offer one residual word, wait for it to be taken, then scan it
  task automatic put_word(input ctslm_pkg::sample_t v, output bit got,
                          output minima_res_t r);
    while ($urandom_range(99) < send_idle_pct()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    residual <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = advance_scan(v, r);
  endtask

  // Receiver: random stall, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct());
    end
  end

  // Compare each result word with the oldest expectation; bound the run
  always @(posedge clk) begin : watch
    minima_res_t got;
    minima_res_t want;
    cycles = cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{first: first_minimum, second: second_minimum, curv: curvature,
              found: minima_found};
      if (pending_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t unexpected result: got first=%0d second=%0d curv=%0d found=%0d",
                 $time, got.first, got.second, got.curv, got.found);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors = errors + 1;
          $display("%0t mismatch: expected first=%0d second=%0d curv=%0d found=%0d",
                   $time, want.first, want.second, want.curv, want.found);
          $display("%0t           actual first=%0d second=%0d curv=%0d found=%0d",
                   $time, got.first, got.second, got.curv, got.found);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stim
    logic [8:0]  ph_cfg[10];
    int          ph_words[10];
    minima_res_t r;
    minima_res_t typed_res;
    bit          got;
    int          i;
    int          k;
    int          ph;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset label count: one dip at label 37 on a flat curve
    typed_res = '{first: 8'd37, second: 8'd37, curv: 34'sd2,
                  found: ctslm_pkg::MINIMA_ONE};
    for (i = 0; i < ctslm_pkg::NUM_LABELS_RESET; i++) begin
      put_word((i == 37) ? -1 : 0, got, r);
      if (i == ctslm_pkg::NUM_LABELS_RESET - 1) queue_result(typed_res);
      else if (got) queue_result(r);
    end

    // Directed voxels
    add_row(mk_cfg(9'd0));         // below range, flat: no minimum
    add_row(mk_word(0));
    add_row(mk_word(0));
    add_row(mk_last(0, 8'd0, 8'd0, 34'sd0, ctslm_pkg::MINIMA_NONE));
    add_row(mk_cfg(9'd2));         // full-scale dip, largest curvature
    add_row(mk_word(S_MAX));
    add_row(mk_word(S_MIN));
    add_row(mk_last(S_MAX, 8'd1, 8'd1, 34'sd8589934590, ctslm_pkg::MINIMA_ONE));
    add_row(mk_cfg(9'd4));         // equal minima: lower label first
    add_row(mk_word(5));
    add_row(mk_word(1));
    add_row(mk_word(5));
    add_row(mk_word(1));
    add_row(mk_word(-10));         // smallest minimum at the wrap
    add_row(mk_word(0));
    add_row(mk_word(-5));
    add_row(mk_word(0));
    add_row(mk_word(3));           // plateau after a fall counts once
    add_row(mk_word(1));
    add_row(mk_word(1));
    add_row(mk_word(3));
    add_row(mk_cfg(9'd6));         // three minima, count saturates
    add_row(mk_word(9));
    add_row(mk_word(2));
    add_row(mk_word(9));
    add_row(mk_word(1));
    add_row(mk_word(9));
    add_row(mk_word(3));
    add_row(mk_cfg(9'd8));         // shrink the count mid-voxel
    add_row(mk_word(4));
    add_row(mk_word(1));
    add_row(mk_word(7));
    add_row(mk_cfg(9'd3));
    add_row(mk_word(0));

    foreach (dir_tab[n]) begin
      if (dir_tab[n].is_cfg) begin
        write_labels(dir_tab[n].cfg);
      end else begin
        put_word(dir_tab[n].word, got, r);
        if (dir_tab[n].typed) queue_result(dir_tab[n].want);
        else if (got) queue_result(r);
      end
    end

    // Random phases: label count and word count per phase
    ph_cfg[0] = 9'($urandom_range(40, 120)); ph_words[0] = 60;
    ph_cfg[1] = 9'd0;                        ph_words[1] = 60;
    ph_cfg[2] = 9'($urandom_range(3, 10));   ph_words[2] = 50;
    ph_cfg[3] = 9'd511;                      ph_words[3] = 256;
    ph_cfg[4] = 9'($urandom_range(4, 16));   ph_words[4] = 60;
    ph_cfg[5] = 9'd5;                        ph_words[5] = 50;
    ph_cfg[6] = 9'd256;                      ph_words[6] = 256;
    ph_cfg[7] = 9'($urandom_range(3, 12));   ph_words[7] = 60;
    ph_cfg[8] = 9'd3;                        ph_words[8] = 90;
    ph_cfg[9] = 9'($urandom_range(3, 40));   ph_words[9] = 80;

    for (ph = 0; ph < 10; ph++) begin
      write_labels(ph_cfg[ph]);
      pace = (ph < 4) ? PACE_SLOW_RX : ((ph < 7) ? PACE_SLOW_TX : PACE_FULL);
      // back the block up into its input with a long output hold-off
      if (ph == 8) hold_req = 1'b1;
      for (k = 0; k < ph_words[ph]; k++) begin
        // pause the sender until every result is out
        if (ph == 8 && k == 45) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(negedge clk);
        end
        if (scan_pos == 0) begin
          case ($urandom_range(9))
            0, 1, 2, 3: voxel_shape = SHAPE_WIDE;
            4, 5, 6:    voxel_shape = SHAPE_NARROW;
            7:          voxel_shape = SHAPE_FLAT;
            default:    voxel_shape = SHAPE_EDGES;
          endcase
          voxel_level = ctslm_pkg::sample_t'($urandom);
        end
        put_word(pick_residual(), got, r);
        if (got) queue_result(r);
      end
    end

    // Drain and report
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
